### hw/rtl/ladsr_pkg.sv
// ---------------------------------------------------------------------------
// ladsr_pkg
// Stage, request and register codes for the linear ADSR envelope.
// ---------------------------------------------------------------------------
package ladsr_pkg;

   typedef logic [2:0] stage_type;
   typedef logic [1:0] req_kind_type;
   typedef logic [1:0] csr_index_type;

   // envelope stages
   localparam stage_type STAGE_ATTACK  = 3'd0;
   localparam stage_type STAGE_DECAY   = 3'd1;
   localparam stage_type STAGE_SUSTAIN = 3'd2;
   localparam stage_type STAGE_RELEASE = 3'd3;
   localparam stage_type STAGE_IDLE    = 3'd4;

   // request kinds
   localparam req_kind_type REQ_TICK     = 2'd0;
   localparam req_kind_type REQ_NOTE_ON  = 2'd1;
   localparam req_kind_type REQ_NOTE_OFF = 2'd2;

   // configuration register indexes
   localparam csr_index_type CSR_ATTACK_STEP   = 2'd0;
   localparam csr_index_type CSR_DECAY_STEP    = 2'd1;
   localparam csr_index_type CSR_SUSTAIN_LEVEL = 2'd2;
   localparam csr_index_type CSR_RELEASE_RATE  = 2'd3;

   localparam int VELOCITY_WIDTH = 7;

endpackage

### hw/rtl/linear_adsr_envelope.sv
// ---------------------------------------------------------------------------
// linear_adsr_envelope
// Linear ADSR envelope for one voice, with velocity-scaled amplitude.
// ---------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   req     | in        | req_valid/req_stall  | req_type, req_velocity
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_level, rsp_amplitude,
//           |           |                      | rsp_stage, rsp_active
//   csr     | in        | csr_wr_en            | csr_index, csr_wdata
//
// One request per cycle is accepted unless req_stall is high; each gives one response.
// The envelope state updates in the accept cycle; the amplitude divide by
// 127 runs in the three stages behind it (multiply, residue, exact divide).
// Reset is synchronous: envelope idle at level 0, registers at defaults.
// A stalled response holds in the output register while the stages behind it
// keep filling; req_stall rises only once every stage is occupied.
// ---------------------------------------------------------------------------
module linear_adsr_envelope
   import ladsr_pkg::*;
#(
   parameter int LEVEL_FRAC_BITS = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_type,
   input  logic [VELOCITY_WIDTH-1:0]  req_velocity,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [LEVEL_FRAC_BITS:0]   rsp_level,
   output logic [LEVEL_FRAC_BITS:0]   rsp_amplitude,
   output logic [2:0]                 rsp_stage,
   output logic                       rsp_active,
   // configuration write port
   input  logic                       csr_wr_en,
   input  logic [1:0]                 csr_index,
   input  logic [LEVEL_FRAC_BITS:0]   csr_wdata
);

   // level width (Q1.F) and product width; level * velocity + 63 < 2^(F+7)
   localparam int LW    = LEVEL_FRAC_BITS + 1;
   localparam int PW    = LEVEL_FRAC_BITS + 7;
   // residue mod 127 from 7-bit digits, since 128 is 1 mod 127
   localparam int NCH   = (PW + 6) / 7;
   localparam int PADW  = NCH * 7;
   localparam int SUMW  = $clog2(NCH * 127 + 1);
   // doublings of the series 1 + 2^7 + 2^14 + ... needed to cover PW bits
   localparam int NDBL  = $clog2(NCH);

   localparam logic [LW-1:0]   FULL_SCALE = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};
   localparam logic [2*LW-1:0] ROUND_HALF = (2*LW)'(1) << (LEVEL_FRAC_BITS - 1);
   localparam logic [63:0]     START_DEF_WIDE =
      ((64'd6 << LEVEL_FRAC_BITS) + 64'd5) / 64'd10;
   localparam logic [LW-1:0]   START_DEFAULT = START_DEF_WIDE[LW-1:0];

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [LW-1:0] attack_step_ff;
   logic [LW-1:0] decay_step_ff;
   logic [LW-1:0] sustain_level_ff;
   logic [LW-1:0] release_rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_step_ff   <= LW'(6990);
         decay_step_ff    <= LW'(466);
         sustain_level_ff <= LW'(10066330);
         release_rate_ff  <= LW'(699);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ATTACK_STEP:   attack_step_ff   <= csr_wdata;
            CSR_DECAY_STEP:    decay_step_ff    <= csr_wdata;
            CSR_SUSTAIN_LEVEL: sustain_level_ff <= csr_wdata;
            CSR_RELEASE_RATE:  release_rate_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // pipeline flow control: a stage loads when it is empty or its
   // occupant moves on in the same cycle
   // ------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic s1_valid_in, s2_valid_in, s3_valid_in, rsp_valid_in;
   logic out_load, s3_load, s2_load, s1_load;
   logic req_accept;

   assign out_load   = !rsp_valid_ff || !rsp_stall;
   assign s3_load    = !s3_valid_ff || out_load;
   assign s2_load    = !s2_valid_ff || s3_load;
   assign s1_load    = !s1_valid_ff || s2_load;
   assign req_stall  = !s1_load;
   assign req_accept = req_valid && s1_load;

   assign s1_valid_in  = s1_load  ? req_valid   : s1_valid_ff;
   assign s2_valid_in  = s2_load  ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in  = s3_load  ? s2_valid_ff : s3_valid_ff;
   assign rsp_valid_in = out_load ? s3_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ------------------------------------------------------------------
   // envelope state, updated on each accepted request
   // ------------------------------------------------------------------
   logic [LW-1:0]             level_ff, level_in;
   logic [2:0]                phase_ff, phase_in;
   logic                      held_ff, held_in;
   logic [LW-1:0]             release_step_ff, release_step_in;
   logic [VELOCITY_WIDTH-1:0] note_velocity_ff, note_velocity_in;

   logic [LW-1:0]   sustain_eff;
   logic [LW-1:0]   rel_base;
   logic [LW-1:0]   rel_start;
   logic [2*LW-1:0] rel_product;
   logic [LW-1:0]   rel_step_calc;
   logic [LW:0]     attack_sum;
   logic [LW:0]     decay_floor;

   // sustain above full scale acts as full scale
   assign sustain_eff = (sustain_level_ff > FULL_SCALE) ? FULL_SCALE : sustain_level_ff;

   // release start: a tick only enters release from sustain, where the level
   // becomes the sustain level first; a note-off starts from the level
   assign rel_base      = (req_type == REQ_TICK) ? sustain_eff : level_ff;
   assign rel_start     = (rel_base == '0) ? START_DEFAULT : rel_base;
   assign rel_product   = (2*LW)'(rel_start) * (2*LW)'(release_rate_ff) + ROUND_HALF;
   assign rel_step_calc = rel_product[LEVEL_FRAC_BITS +: LW];

   assign attack_sum  = {1'b0, level_ff} + {1'b0, attack_step_ff};
   assign decay_floor = {1'b0, sustain_eff} + {1'b0, decay_step_ff};

   always_comb begin
      level_in         = level_ff;
      phase_in         = phase_ff;
      held_in          = held_ff;
      release_step_in  = release_step_ff;
      note_velocity_in = note_velocity_ff;
      if (req_accept) begin
         priority if (req_type == REQ_TICK) begin
            unique case (phase_ff)
               STAGE_ATTACK: begin
                  // rise, saturate at full scale
                  if (attack_sum >= {1'b0, FULL_SCALE}) begin
                     level_in = FULL_SCALE;
                     phase_in = STAGE_DECAY;
                  end else begin
                     level_in = attack_sum[LW-1:0];
                  end
               end
               STAGE_DECAY: begin
                  // fall, clamp at sustain
                  if ({1'b0, level_ff} <= decay_floor) begin
                     level_in = sustain_eff;
                     phase_in = STAGE_SUSTAIN;
                  end else begin
                     level_in = level_ff - decay_step_ff;
                  end
               end
               STAGE_SUSTAIN: begin
                  level_in = sustain_eff;
                  if (!held_ff) begin
                     release_step_in = rel_step_calc;
                     phase_in        = STAGE_RELEASE;
                  end
               end
               STAGE_RELEASE: begin
                  // fall by the latched step, then go idle at zero
                  if (level_ff <= release_step_ff) begin
                     level_in = '0;
                     phase_in = STAGE_IDLE;
                  end else begin
                     level_in = level_ff - release_step_ff;
                  end
               end
               default: ;
            endcase
         end else if (req_type == REQ_NOTE_ON && req_velocity != '0) begin
            // restart the voice from zero
            level_in         = '0;
            phase_in         = STAGE_ATTACK;
            held_in          = 1'b1;
            release_step_in  = '0;
            note_velocity_in = req_velocity;
         end else if (req_type == REQ_NOTE_ON || req_type == REQ_NOTE_OFF) begin
            // note-off, or note-on at zero velocity
            held_in = 1'b0;
            if (phase_ff < STAGE_RELEASE) begin
               release_step_in = rel_step_calc;
               phase_in        = STAGE_RELEASE;
            end
         end else begin
            // unused request kind: state holds
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff         <= '0;
         phase_ff         <= STAGE_IDLE;
         held_ff          <= 1'b0;
         release_step_ff  <= '0;
         note_velocity_ff <= '0;
      end else begin
         level_ff         <= level_in;
         phase_ff         <= phase_in;
         held_ff          <= held_in;
         release_step_ff  <= release_step_in;
         note_velocity_ff <= note_velocity_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 1: snapshot of the state after the request
   // ------------------------------------------------------------------
   logic [LW-1:0]             s1_level_ff;
   logic [VELOCITY_WIDTH-1:0] s1_velocity_ff;
   logic [2:0]                s1_phase_ff;

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_level_ff    <= level_in;
         s1_velocity_ff <= note_velocity_in;
         s1_phase_ff    <= phase_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 2: level * velocity + 63 (rounding bias for the divide)
   // ------------------------------------------------------------------
   logic [LW+VELOCITY_WIDTH-1:0] s2_product;
   logic [PW-1:0]                s2_biased_ff;
   logic [LW-1:0]                s2_level_ff;
   logic [2:0]                   s2_phase_ff;

   assign s2_product = (LW+VELOCITY_WIDTH)'(s1_level_ff) * (LW+VELOCITY_WIDTH)'(s1_velocity_ff)
                     + (LW+VELOCITY_WIDTH)'(63);

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_biased_ff <= s2_product[PW-1:0];
         s2_level_ff  <= s1_level_ff;
         s2_phase_ff  <= s1_phase_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 3: residue of the biased product mod 127
   // ------------------------------------------------------------------
   logic [PADW-1:0] s3_padded;
   logic [SUMW-1:0] s3_digit_sum;
   logic [7:0]      s3_fold;
   logic [6:0]      s3_residue;
   logic [PW-1:0]   s3_biased_ff;
   logic [6:0]      s3_residue_ff;
   logic [LW-1:0]   s3_level_ff;
   logic [2:0]      s3_phase_ff;

   assign s3_padded = PADW'(s2_biased_ff);

   always_comb begin
      s3_digit_sum = '0;
      for (int i = 0; i < NCH; i++) begin
         s3_digit_sum = s3_digit_sum + SUMW'(s3_padded[7*i +: 7]);
      end
   end

   // one more fold brings the sum below 2 * 127
   assign s3_fold    = {1'b0, s3_digit_sum[6:0]} + 8'(s3_digit_sum >> 7);
   assign s3_residue = (s3_fold >= 8'd127) ? 7'(s3_fold - 8'd127) : s3_fold[6:0];

   always_ff @(posedge clock) begin
      if (s3_load) begin
         s3_biased_ff  <= s2_biased_ff;
         s3_residue_ff <= s3_residue;
         s3_level_ff   <= s2_level_ff;
         s3_phase_ff   <= s2_phase_ff;
      end
   end

   // ------------------------------------------------------------------
   // output stage: exact divide of the multiple of 127, by multiplying
   // with the inverse of 127 mod 2^PW, -(1 + 2^7 + 2^14 + ...)
   // ------------------------------------------------------------------
   logic [PW-1:0] out_multiple;
   logic [PW-1:0] out_series;
   logic [PW-1:0] out_quotient;

   logic [LW-1:0] rsp_level_ff;
   logic [LW-1:0] rsp_amplitude_ff;
   logic [2:0]    rsp_stage_ff;
   logic          rsp_active_ff;

   assign out_multiple = s3_biased_ff - PW'(s3_residue_ff);

   always_comb begin
      out_series = out_multiple;
      for (int i = 0; i < NDBL; i++) begin
         out_series = out_series + (out_series << (7 << i));
      end
   end

   assign out_quotient = ~out_series + PW'(1);

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_level_ff     <= s3_level_ff;
         rsp_amplitude_ff <= out_quotient[LW-1:0];
         rsp_stage_ff     <= s3_phase_ff;
         rsp_active_ff    <= (s3_phase_ff != STAGE_IDLE);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_level     = rsp_level_ff;
   assign rsp_amplitude = rsp_amplitude_ff;
   assign rsp_stage     = rsp_stage_ff;
   assign rsp_active    = rsp_active_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   // a held note never sits in release or idle
   assert property (@(posedge clock) disable iff (reset)
      held_ff |-> (phase_ff < STAGE_RELEASE))
      else $error("held note outside attack, decay or sustain");

   // velocity scaling never raises the level
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_amplitude_ff <= rsp_level_ff))
      else $error("amplitude above envelope level");

   // level stays within full scale
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_level_ff <= FULL_SCALE))
      else $error("envelope level above full scale");

   // an idle voice reports zero level and amplitude
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stage_ff == STAGE_IDLE) |->
         (rsp_level_ff == '0 && rsp_amplitude_ff == '0))
      else $error("idle voice with nonzero level");

   // an empty first stage never stalls the request side
   assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> !req_stall)
      else $error("request stalled with empty pipeline");

endmodule
